[src/s1md_pkg.sv]
// ----------------------------------------------------------------------------
// s1md_pkg: shared definitions for the SHA-1 message digest core
// Request format, queue status, the SHA-1 constants and default settings.
// ----------------------------------------------------------------------------
package s1md_pkg;

  // Default message length modulus in bits, and default request queue depth.
  localparam int LENGTH_BITS_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Initial chaining words, word 0 in the lowest slot.
  localparam logic [4:0][31:0] H_INIT = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  // Round constants, one for each group of twenty rounds.
  localparam logic [31:0] K_CH  = 32'h5a827999;
  localparam logic [31:0] K_PA1 = 32'h6ed9eba1;
  localparam logic [31:0] K_MAJ = 32'h8f1bbcdc;
  localparam logic [31:0] K_PA2 = 32'hca62c1d6;

  // Marker byte that follows the last message byte.
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // One classified request, as it travels through the queue.
  typedef struct packed {
    logic       has_byte;
    logic       last;
    logic [7:0] data;
  } s1md_req_t;

  // Fill status of the request queue.
  typedef struct packed {
    logic full;
    logic empty;
  } s1md_qstat_t;

endpackage

[src/s1md_front.sv]
// ----------------------------------------------------------------------------
// s1md_front: input stage of the SHA-1 core
// Takes requests, drops those that carry neither a byte nor an end mark, and
// holds the rest in a register until the queue has room.
// ----------------------------------------------------------------------------
module s1md_front
  import s1md_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  input  s1md_qstat_t qstat,
  output logic        push,
  output s1md_req_t   push_req
);

  logic      req_valid_r;
  logic      req_valid_nxt;
  s1md_req_t req_r;
  logic      accept;
  logic      useful;

  assign in_stall = req_valid_r & qstat.full;
  assign accept   = in_valid & ~in_stall;
  assign useful   = in_has_byte | in_end_of_message;
  assign push     = req_valid_r & ~qstat.full;
  assign push_req = req_r;

  assign req_valid_nxt = (req_valid_r & qstat.full) | (accept & useful);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && useful) begin
      req_r.has_byte <= in_has_byte;
      req_r.last     <= in_end_of_message;
      req_r.data     <= in_data_byte;
    end
  end

endmodule

[src/s1md_queue.sv]
// ----------------------------------------------------------------------------
// s1md_queue: request queue between front and back of the SHA-1 core
// A small first-in first-out store of classified requests.
// ----------------------------------------------------------------------------
module s1md_queue
  import s1md_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  s1md_req_t   push_req,
  input  logic        pop,
  output s1md_req_t   head_req,
  output s1md_qstat_t qstat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  s1md_req_t     mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign qstat.full  = (cnt_r == FULL_CNT);
  assign qstat.empty = (cnt_r == '0);
  assign head_req    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

[src/s1md_back.sv]
// ----------------------------------------------------------------------------
// s1md_back: block buffer, compression engine and digest output
// Packs bytes into sixteen message words, pads the final block, runs one
// SHA-1 round per cycle and returns the five digest words.
// ----------------------------------------------------------------------------
module s1md_back
  import s1md_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  s1md_qstat_t qstat,
  input  s1md_req_t   head_req,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  // Only the byte count modulo 2^(LENGTH_BITS-3) ever matters.
  localparam int CNT_W = LENGTH_BITS - 3;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROUND = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_LEN   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_WORD  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [6:0]        round_r, round_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              end_pend_r, end_pend_nxt;
  logic              len_pend_r, len_pend_nxt;
  logic              final_r, final_nxt;
  logic [2:0]        oidx_r, oidx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [4:0][31:0]  h_r, h_nxt;
  logic [15:0][31:0] w_r, w_nxt;
  logic [31:0]       a_r, b_r, c_r, d_r, e_r;
  logic [31:0]       a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0]       out_word_r;
  logic [2:0]        out_index_r;
  logic              out_last_r;
  logic              out_load;

  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;
  logic [31:0] w_new;
  logic [5:0]  pos;
  logic [63:0] bit_len;

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_index_r;
  assign out_last_word   = out_last_r;

  assign pos     = cnt_r[5:0];
  assign bit_len = 64'({cnt_r, 3'b000});
  assign pop     = (state_r == ST_IDLE) && !end_pend_r && !qstat.empty;

  // Round function and constant for the current round.
  always_comb begin
    priority if (round_r < 7'd20) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = K_CH;
    end else if (round_r < 7'd40) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_PA1;
    end else if (round_r < 7'd60) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = K_MAJ;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_PA2;
    end
  end

  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + w_r[0];
  assign w_new = {w_r[13][30:0] ^ w_r[8][30:0] ^ w_r[2][30:0] ^ w_r[0][30:0],
                  w_r[13][31] ^ w_r[8][31] ^ w_r[2][31] ^ w_r[0][31]};

  always_comb begin
    logic [5:0] jj;
    logic [1:0] lane;
    jj            = '0;
    lane          = 2'd3 - pos[1:0];
    state_nxt     = state_r;
    round_nxt     = round_r;
    cnt_nxt       = cnt_r;
    end_pend_nxt  = end_pend_r;
    len_pend_nxt  = len_pend_r;
    final_nxt     = final_r;
    oidx_nxt      = oidx_r;
    h_nxt         = h_r;
    w_nxt         = w_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r & out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (end_pend_r) begin
          // Marker byte at the fill position, zeros after it.
          end_pend_nxt = 1'b0;
          for (int i = 0; i < 16; i++) begin
            for (int b = 0; b < 4; b++) begin
              jj = 6'(4 * i + b);
              if (jj == pos) begin
                w_nxt[i][31 - 8 * b -: 8] = PAD_BYTE;
              end else if (jj > pos) begin
                w_nxt[i][31 - 8 * b -: 8] = 8'h00;
              end
            end
          end
          if (pos >= 6'd56) begin
            len_pend_nxt = 1'b1;
            final_nxt    = 1'b0;
          end else begin
            w_nxt[14] = bit_len[63:32];
            w_nxt[15] = bit_len[31:0];
            final_nxt = 1'b1;
          end
          state_nxt = ST_ROUND;
          round_nxt = '0;
          {a_nxt, b_nxt, c_nxt, d_nxt, e_nxt} = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4]};
        end else if (!qstat.empty) begin
          end_pend_nxt = head_req.last;
          if (head_req.has_byte) begin
            w_nxt[pos[5:2]][{lane, 3'b000} +: 8] = head_req.data;
            cnt_nxt = cnt_r + 1'b1;
            if (pos == 6'd63) begin
              // Block full: compress before anything else.
              final_nxt = 1'b0;
              state_nxt = ST_ROUND;
              round_nxt = '0;
              {a_nxt, b_nxt, c_nxt, d_nxt, e_nxt} =
                {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4]};
            end
          end
        end
      end

      ST_ROUND: begin
        e_nxt = d_r;
        d_nxt = c_r;
        c_nxt = {b_r[1:0], b_r[31:2]};
        b_nxt = a_r;
        a_nxt = t_val;
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i + 1];
        end
        w_nxt[15] = w_new;
        round_nxt = round_r + 1'b1;
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end

      ST_ADD: begin
        h_nxt[0] = h_r[0] + a_r;
        h_nxt[1] = h_r[1] + b_r;
        h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r;
        h_nxt[4] = h_r[4] + e_r;
        if (final_r) begin
          state_nxt = ST_OUT;
          oidx_nxt  = '0;
        end else if (len_pend_r) begin
          state_nxt = ST_LEN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_LEN: begin
        // Second final block: only the length.
        len_pend_nxt = 1'b0;
        final_nxt    = 1'b1;
        w_nxt        = '0;
        w_nxt[14]    = bit_len[63:32];
        w_nxt[15]    = bit_len[31:0];
        state_nxt    = ST_ROUND;
        round_nxt    = '0;
        {a_nxt, b_nxt, c_nxt, d_nxt, e_nxt} = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4]};
      end

      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          oidx_nxt      = oidx_r + 1'b1;
          if (oidx_r == LAST_WORD) begin
            h_nxt     = H_INIT;
            cnt_nxt   = '0;
            final_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= '0;
      cnt_r       <= '0;
      end_pend_r  <= 1'b0;
      len_pend_r  <= 1'b0;
      final_r     <= 1'b0;
      oidx_r      <= '0;
      out_valid_r <= 1'b0;
      h_r         <= H_INIT;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      cnt_r       <= cnt_nxt;
      end_pend_r  <= end_pend_nxt;
      len_pend_r  <= len_pend_nxt;
      final_r     <= final_nxt;
      oidx_r      <= oidx_nxt;
      out_valid_r <= out_valid_nxt;
      h_r         <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
    e_r <= e_nxt;
    if (out_load) begin
      out_word_r  <= h_r[oidx_r];
      out_index_r <= oidx_r;
      out_last_r  <= (oidx_r == LAST_WORD);
    end
  end

  // The round counter never runs past the last round.
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND |-> round_r <= LAST_ROUND)
    else $error("round counter out of range");

  // The last round always hands over to the chaining update.
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND && round_r == LAST_ROUND |=> state_r == ST_ADD)
    else $error("compression did not end in the chaining update");

  // Requests leave the queue only when the engine is free.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == ST_IDLE && !end_pend_r && !qstat.empty)
    else $error("request taken while the engine was busy");

  // After the final compression the digest goes out next.
  a_final_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ADD && final_r |=> state_r == ST_OUT && oidx_r == 3'd0)
    else $error("final compression not followed by digest output");

endmodule

[src/sha1_message_digest_core.sv]
// ----------------------------------------------------------------------------
// sha1_message_digest_core: SHA-1 digest of a byte-serial message
// Front stage, request queue and compression engine with digest output.
// ----------------------------------------------------------------------------
// The core hashes a message that arrives one byte per request and, after the
// request that carries the end mark, returns the five SHA-1 digest words,
// word 0 first, with the last one flagged; it is then ready for a new message.
// The engine takes in one byte at a time, and every 64th byte starts a
// compression (80 rounds at one round per cycle, then an update of the
// chaining words), during which the engine takes no bytes. The end mark
// costs a padding step and one compression. When fewer than nine bytes of
// the last block remain free, it costs a padding step, two compressions and
// a length step between them. The digest words then go out in order, each
// held while out_stall is high. A request queue of QUEUE_DEPTH entries and
// an input register lets requests keep arriving while a compression is under
// way. LENGTH_BITS sets the modulus of the bit length written into the final
// block.
// ----------------------------------------------------------------------------
module sha1_message_digest_core
  import s1md_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  // Queue status is seen by both sides, so each can stall on its own.
  s1md_qstat_t qstat;
  s1md_req_t   push_req;
  s1md_req_t   head_req;
  logic        push;
  logic        pop;

  s1md_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .qstat             (qstat),
    .push              (push),
    .push_req          (push_req)
  );

  s1md_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head_req (head_req),
    .qstat    (qstat)
  );

  // The engine holds the block, the byte count and the chaining words.
  s1md_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .qstat           (qstat),
    .head_req        (head_req),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule
